@@ src/pfa_pkg.sv @@
// shared constants, codes and control types of the page frame allocator
`timescale 1ns / 1ps
package pfa_pkg;

    localparam int NUM_FRAMES = 64;
    localparam int FRAME_W    = 6;
    localparam int COUNT_W    = 7;
    localparam int PID_W      = 8;
    localparam int BYTES_W    = 16;
    localparam int STATUS_W   = 2;
    localparam int DIV_CNT_W  = $clog2(BYTES_W + 1);

    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED  = 2'd0,
        ST_SHORT    = 2'd1,
        ST_RELEASED = 2'd2,
        ST_IDLE     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        SRC_ZERO = 2'd0,
        SRC_POP  = 2'd1,
        SRC_HOLD = 2'd2
    } t_src;

    typedef struct packed {
        logic    latch_req;
        logic    div_start;
        logic    load_left;
        logic    pop_rd;
        logic    grant;
        logic    scan_clear;
        logic    scan_rd;
        logic    release_frame;
        logic    scan_next;
        logic    emit;
        t_src    emit_src;
        t_status emit_status;
        logic    emit_last;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic need_zero;
        logic need_short;
        logic left_one;
        logic hit;
        logic hold_valid;
        logic scan_last;
        logic out_free;
    } t_sts;

endpackage

@@ src/pfa_if.sv @@
// request, result and configuration channel interfaces
`timescale 1ns / 1ps
interface pfa_req_if import pfa_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               action;
    logic [PID_W-1:0]   process_id;
    logic [BYTES_W-1:0] request_bytes;

    modport source (output valid, action, process_id, request_bytes, input ready);
    modport sink   (input valid, action, process_id, request_bytes, output ready);
endinterface

interface pfa_res_if import pfa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [FRAME_W-1:0]  frame_index;
    logic [STATUS_W-1:0] status;
    logic                last;

    modport source (output valid, frame_index, status, last, input ready);
    modport sink   (input valid, frame_index, status, last, output ready);
endinterface

interface pfa_cfg_if import pfa_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [BYTES_W-1:0] page_bytes;

    modport source (output valid, page_bytes, input ready);
    modport sink   (input valid, page_bytes, output ready);
endinterface

@@ src/pfa_div.sv @@
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module pfa_div import pfa_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [BYTES_W-1:0] i_dividend,
    input  logic [BYTES_W-1:0] i_divisor,
    output logic               o_done,
    output logic [BYTES_W-1:0] o_quo,
    output logic [BYTES_W-1:0] o_rem
);

    logic [DIV_CNT_W-1:0] r_cnt;
    logic [BYTES_W-1:0]   r_quo;
    logic [BYTES_W-1:0]   r_rem;
    logic [BYTES_W-1:0]   r_div;
    logic [BYTES_W:0]     shifted;
    logic [BYTES_W+1:0]   diff;

    assign shifted = {r_rem, r_quo[BYTES_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= DIV_CNT_W'(BYTES_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            if (!diff[BYTES_W+1]) begin
                r_rem <= diff[BYTES_W-1:0];
                r_quo <= {r_quo[BYTES_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted[BYTES_W-1:0];
                r_quo <= {r_quo[BYTES_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = (r_cnt == '0);
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

@@ src/pfa_dp.sv @@
// datapath: free-frame queue, owner table, busy flags, scan and result register
`timescale 1ns / 1ps
module pfa_dp import pfa_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic                i_cfg_valid,
    input  logic [BYTES_W-1:0]  i_cfg_page_bytes,
    input  logic [PID_W-1:0]    i_req_pid,
    input  logic [BYTES_W-1:0]  i_req_bytes,
    input  logic                i_res_ready,
    output logic                o_res_valid,
    output logic [FRAME_W-1:0]  o_res_frame,
    output logic [STATUS_W-1:0] o_res_status,
    output logic                o_res_last
);

    logic [BYTES_W-1:0]    r_page_bytes;
    logic [PID_W-1:0]      r_pid;
    logic [COUNT_W-1:0]    r_left;
    logic [FRAME_W-1:0]    r_head;
    logic [FRAME_W-1:0]    r_tail;
    logic [COUNT_W-1:0]    r_free_count;
    logic [NUM_FRAMES-1:0] r_busy;
    logic [NUM_FRAMES-1:0] r_qv;
    logic [FRAME_W-1:0]    r_queue [NUM_FRAMES];
    logic [PID_W-1:0]      r_owner [NUM_FRAMES];
    logic [FRAME_W-1:0]    r_pop_q;
    logic                  r_pop_v;
    logic [PID_W-1:0]      r_own_q;
    logic                  r_busy_q;
    logic [FRAME_W-1:0]    r_scan;
    logic                  r_hold_v;
    logic [FRAME_W-1:0]    r_hold_frame;
    logic                  r_out_valid;
    logic [FRAME_W-1:0]    r_out_frame;
    logic [STATUS_W-1:0]   r_out_status;
    logic                  r_out_last;

    logic [BYTES_W-1:0]    divisor;
    logic                  div_done;
    logic [BYTES_W-1:0]    div_quo;
    logic [BYTES_W-1:0]    div_rem;
    logic [BYTES_W-1:0]    need;
    logic [FRAME_W-1:0]    pop_frame;
    logic                  out_free;
    logic [FRAME_W-1:0]    emit_frame;

    assign divisor = (r_page_bytes == '0) ? BYTES_W'(1) : r_page_bytes;

    pfa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (i_req_bytes),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    function automatic logic [FRAME_W-1:0] next_pos(input logic [FRAME_W-1:0] p);
        next_pos = (p == FRAME_W'(NUM_FRAMES - 1)) ? '0 : p + FRAME_W'(1);
    endfunction

    assign need      = div_quo + BYTES_W'(div_rem != '0);
    assign pop_frame = r_pop_v ? r_pop_q : r_head;
    assign out_free  = !r_out_valid || i_res_ready;

    always_comb begin
        case (i_cmd.emit_src)
            SRC_POP:  emit_frame = pop_frame;
            SRC_HOLD: emit_frame = r_hold_frame;
            default:  emit_frame = '0;
        endcase
    end

    assign o_sts.div_done   = div_done;
    assign o_sts.need_zero  = (need == '0);
    assign o_sts.need_short = (need > BYTES_W'(r_free_count));
    assign o_sts.left_one   = (r_left == COUNT_W'(1));
    assign o_sts.hit        = r_busy_q && (r_own_q == r_pid);
    assign o_sts.hold_valid = r_hold_v;
    assign o_sts.scan_last  = (r_scan == FRAME_W'(NUM_FRAMES - 1));
    assign o_sts.out_free   = out_free;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_bytes <= BYTES_W'(4096);
            r_head       <= '0;
            r_tail       <= '0;
            r_free_count <= COUNT_W'(NUM_FRAMES);
            r_busy       <= '0;
            r_qv         <= '0;
            r_hold_v     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_page_bytes <= i_cfg_page_bytes;
            end
            if (i_cmd.grant) begin
                r_head               <= next_pos(r_head);
                r_free_count         <= r_free_count - COUNT_W'(1);
                r_busy[pop_frame]    <= 1'b1;
            end
            if (i_cmd.release_frame) begin
                r_tail               <= next_pos(r_tail);
                r_free_count         <= r_free_count + COUNT_W'(1);
                r_busy[r_scan]       <= 1'b0;
                r_qv[r_tail]         <= 1'b1;
            end
            if (i_cmd.scan_clear) begin
                r_hold_v <= 1'b0;
            end else if (i_cmd.release_frame) begin
                r_hold_v <= 1'b1;
            end
            if (i_cmd.emit && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers and memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_req) begin
            r_pid <= i_req_pid;
        end
        if (i_cmd.load_left) begin
            r_left <= need[COUNT_W-1:0];
        end else if (i_cmd.grant) begin
            r_left <= r_left - COUNT_W'(1);
        end
        if (i_cmd.scan_clear) begin
            r_scan <= '0;
        end else if (i_cmd.scan_next) begin
            r_scan <= r_scan + FRAME_W'(1);
        end
        if (i_cmd.release_frame) begin
            r_hold_frame <= r_scan;
        end
        if (i_cmd.pop_rd) begin
            r_pop_q <= r_queue[r_head];
            r_pop_v <= r_qv[r_head];
        end
        if (i_cmd.scan_rd) begin
            r_own_q  <= r_owner[r_scan];
            r_busy_q <= r_busy[r_scan];
        end
        if (i_cmd.release_frame) begin
            r_queue[r_tail] <= r_scan;
        end
        if (i_cmd.grant) begin
            r_owner[pop_frame] <= r_pid;
        end
        if (i_cmd.emit && out_free) begin
            r_out_frame  <= emit_frame;
            r_out_status <= i_cmd.emit_status;
            r_out_last   <= i_cmd.emit_last;
        end
    end

    assign o_res_valid  = r_out_valid;
    assign o_res_frame  = r_out_frame;
    assign o_res_status = r_out_status;
    assign o_res_last   = r_out_last;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_count <= COUNT_W'(NUM_FRAMES))
        else $error("free count above frame total");

    a_queue_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == r_tail) == (r_free_count == '0 || r_free_count == COUNT_W'(NUM_FRAMES)))
        else $error("queue pointers disagree with free count");

    a_grant_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.grant |-> !r_busy[pop_frame] && r_free_count != '0)
        else $error("granting a frame that is not free");

    a_release_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.release_frame |-> r_busy_q && r_busy[r_scan] && r_own_q == r_pid)
        else $error("releasing a frame not owned by the process");

endmodule

@@ src/pfa_ctrl.sv @@
// controller state machine sequencing divide, pops, scan and result beats
`timescale 1ns / 1ps
module pfa_ctrl import pfa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  logic i_req_action,
    output logic o_req_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_DIV      = 9'b000000010,
        S_DECIDE   = 9'b000000100,
        S_POP_RD   = 9'b000001000,
        S_POP_WR   = 9'b000010000,
        S_SCAN_RD  = 9'b000100000,
        S_SCAN_CHK = 9'b001000000,
        S_SCAN_END = 9'b010000000,
        S_WAIT     = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   go;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        go          = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.latch_req = 1'b1;
                    if (i_req_action == ACT_RELEASE) begin
                        o_cmd.scan_clear = 1'b1;
                        n_state          = S_SCAN_RD;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_WAIT;
                    end
                end
            end
            S_WAIT: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.need_zero || i_sts.need_short) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_src    = SRC_ZERO;
                    o_cmd.emit_status = i_sts.need_zero ? ST_IDLE : ST_SHORT;
                    o_cmd.emit_last   = 1'b1;
                    if (i_sts.out_free) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.load_left = 1'b1;
                    n_state         = S_POP_RD;
                end
            end
            S_POP_RD: begin
                o_cmd.pop_rd = 1'b1;
                n_state      = S_POP_WR;
            end
            S_POP_WR: begin
                o_cmd.emit        = 1'b1;
                o_cmd.emit_src    = SRC_POP;
                o_cmd.emit_status = ST_GRANTED;
                o_cmd.emit_last   = i_sts.left_one;
                if (i_sts.out_free) begin
                    o_cmd.grant = 1'b1;
                    n_state     = i_sts.left_one ? S_IDLE : S_POP_RD;
                end
            end
            S_SCAN_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state       = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (i_sts.hit) begin
                    // a held frame goes out once a later one proves it is not the last
                    if (i_sts.hold_valid) begin
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_src    = SRC_HOLD;
                        o_cmd.emit_status = ST_RELEASED;
                        o_cmd.emit_last   = 1'b0;
                        go                = i_sts.out_free;
                    end else begin
                        go = 1'b1;
                    end
                    o_cmd.release_frame = go;
                end else begin
                    go = 1'b1;
                end
                if (go) begin
                    if (i_sts.scan_last) begin
                        n_state = S_SCAN_END;
                    end else begin
                        o_cmd.scan_next = 1'b1;
                        n_state         = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_END: begin
                o_cmd.emit        = 1'b1;
                o_cmd.emit_src    = i_sts.hold_valid ? SRC_HOLD : SRC_ZERO;
                o_cmd.emit_status = i_sts.hold_valid ? ST_RELEASED : ST_IDLE;
                o_cmd.emit_last   = 1'b1;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ src/page_frame_allocator_top.sv @@
// top level of the page frame allocator
`timescale 1ns / 1ps
// Page frame allocator over 64 frames with a FIFO free list and an owner table.
// After an allocate beat is accepted, the 16-step size divide runs and the
// decision follows. A zero-size or short request puts out its single result
// after the decision. Otherwise each granted frame goes through a registered
// free-list read, then the grant.
// After a release beat is accepted, the scan visits all 64 frames, each with a
// read and a check through the single registered owner-table read port, then
// puts out the final beat.
// A full result register that is not taken stalls every beat that is to go out.
// One result beat per frame, or a single beat with status 1 or 3; last marks the
// final beat. A new request is taken while the final result still waits to be
// taken. The page size register may be written only while the block is idle.
module page_frame_allocator_top import pfa_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    pfa_cfg_if.sink   i_cfg,
    pfa_req_if.sink   i_req,
    pfa_res_if.source o_res
);

    t_cmd cmd;
    t_sts sts;
    logic req_ready;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = req_ready;

    pfa_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req.valid),
        .i_req_action (i_req.action),
        .o_req_ready  (req_ready),
        .i_sts        (sts),
        .o_cmd        (cmd)
    );

    pfa_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_valid      (i_cfg.valid),
        .i_cfg_page_bytes (i_cfg.page_bytes),
        .i_req_pid        (i_req.process_id),
        .i_req_bytes      (i_req.request_bytes),
        .i_res_ready      (o_res.ready),
        .o_res_valid      (o_res.valid),
        .o_res_frame      (o_res.frame_index),
        .o_res_status     (o_res.status),
        .o_res_last       (o_res.last)
    );

endmodule

@@ bench/tb.sv @@
// self-checking testbench for the page frame allocator
`timescale 1ns / 1ps
module tb import pfa_pkg::*; ();

    localparam int RUN_LIMIT    = 1_500_000;
    localparam int PRESSURE_LEN = 500;
    localparam int TAIL_CYCLES  = 200;
    localparam int PHASE_ITEMS  = 40;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        t_status            status;
        logic               last;
    } t_frame_beat;

    class t_frame_ledger;
        logic [FRAME_W-1:0] free_ring [NUM_FRAMES];
        int unsigned        ring_head;
        int unsigned        ring_tail;
        int unsigned        free_left;
        bit                 frame_taken [NUM_FRAMES];
        logic [PID_W-1:0]   frame_pid [NUM_FRAMES];
        int unsigned        page_len;
        t_frame_beat        pending_beats [$];
        int errors;
        int n_requests;
        int n_granted;
        int n_released;
        int n_short;
        int n_empty;

        function new();
            page_len  = 4096;
            ring_head = 0;
            ring_tail = 0;
            free_left = NUM_FRAMES;
            for (int i = 0; i < NUM_FRAMES; i++) begin
                free_ring[i]   = FRAME_W'(i);
                frame_taken[i] = 1'b0;
                frame_pid[i]   = '0;
            end
        endfunction

        function void note_request(logic act, logic [PID_W-1:0] pid,
                                   logic [BYTES_W-1:0] bytes);
            int unsigned        pb;
            int unsigned        need;
            t_status            st;
            logic [FRAME_W-1:0] frames [$];
            logic [FRAME_W-1:0] f;
            t_frame_beat        beat;
            n_requests++;
            if (act == ACT_ALLOC) begin
                pb   = (page_len == 0) ? 1 : page_len;
                need = (int'(bytes) + pb - 1) / pb;
                if (need == 0) begin
                    st = ST_IDLE;
                    frames.push_back('0);
                end else if (need > free_left) begin
                    st = ST_SHORT;
                    frames.push_back('0);
                end else begin
                    st = ST_GRANTED;
                    for (int g = 0; g < need; g++) begin
                        f = free_ring[ring_head];
                        ring_head = (ring_head + 1) % NUM_FRAMES;
                        free_left--;
                        frame_taken[f] = 1'b1;
                        frame_pid[f]   = pid;
                        frames.push_back(f);
                    end
                end
            end else begin
                st = ST_RELEASED;
                for (int i = 0; i < NUM_FRAMES; i++) begin
                    if (frame_taken[i] && frame_pid[i] == pid) begin
                        frame_taken[i] = 1'b0;
                        free_ring[ring_tail] = FRAME_W'(i);
                        ring_tail = (ring_tail + 1) % NUM_FRAMES;
                        free_left++;
                        frames.push_back(FRAME_W'(i));
                    end
                end
                if (frames.size() == 0) begin
                    st = ST_IDLE;
                    frames.push_back('0);
                end
            end
            for (int k = 0; k < frames.size(); k++) begin
                beat.frame  = frames[k];
                beat.status = st;
                beat.last   = (k == frames.size() - 1);
                pending_beats.push_back(beat);
            end
        endfunction

        function void check_result(logic [FRAME_W-1:0] f, logic [STATUS_W-1:0] st,
                                   logic l);
            t_frame_beat want;
            if (pending_beats.size() == 0) begin
                $display("%0t: unexpected result beat, frame %0d status %0d last %0d",
                         $time, f, st, l);
                errors++;
                return;
            end
            want = pending_beats.pop_front();
            if (st !== want.status) begin
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, want.status, st);
                errors++;
            end
            if (f !== want.frame) begin
                $display("%0t: frame_index mismatch, expected %0d, actual %0d",
                         $time, want.frame, f);
                errors++;
            end
            if (l !== want.last) begin
                $display("%0t: last mismatch, expected %0d, actual %0d",
                         $time, want.last, l);
                errors++;
            end
            case (want.status)
                ST_GRANTED:  n_granted++;
                ST_RELEASED: n_released++;
                ST_SHORT:    n_short++;
                default:     n_empty++;
            endcase
        endfunction

        function int waiting();
            return pending_beats.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   quiet;
    bit   pressure_req;
    int   cycles;
    int   n_pages;
    t_frame_ledger ledger;

    pfa_req_if req_ch ();
    pfa_res_if res_ch ();
    pfa_cfg_if cfg_ch ();

    page_frame_allocator_top uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int gap_draw();
        return quiet ? 0 : int'($urandom_range(0, 10));
    endfunction

    task automatic drive_request(logic act, logic [PID_W-1:0] pid,
                                 logic [BYTES_W-1:0] bytes);
        int gap;
        gap = gap_draw();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.action        <= act;
        req_ch.process_id    <= pid;
        req_ch.request_bytes <= bytes;
        @(posedge clk);
        while (req_ch.ready !== 1'b1) @(posedge clk);
        ledger.note_request(act, pid, bytes);
        @(negedge clk);
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        while (ledger.waiting() != 0) @(negedge clk);
    endtask

    task automatic write_page(logic [BYTES_W-1:0] value);
        settle();
        cfg_ch.valid      <= 1'b1;
        cfg_ch.page_bytes <= value;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1) @(posedge clk);
        ledger.page_len = value;
        n_pages++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_item();
        int unsigned r;
        int unsigned pb;
        int unsigned need;
        longint      bytes;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            drive_request(1'($urandom), 8'($urandom), 16'($urandom));
        end else if (r < 40) begin
            drive_request(ACT_RELEASE, 8'($urandom_range(0, 7)), 16'($urandom));
        end else begin
            pb   = (ledger.page_len == 0) ? 1 : ledger.page_len;
            need = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 64)
                                                : $urandom_range(0, 12);
            bytes = (need == 0) ? 0
                                : longint'(need - 1) * pb + $urandom_range(1, pb);
            if (bytes > 65535) bytes = 65535;
            drive_request(ACT_ALLOC, 8'($urandom_range(0, 7)), 16'(bytes));
        end
    endtask

    initial begin : result_sink
        int gap;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            if (pressure_req) begin
                res_ch.ready <= 1'b0;
                for (int c = 0; c < PRESSURE_LEN; c++) @(negedge clk);
                pressure_req = 1'b0;
            end else begin
                gap = gap_draw();
                if (gap > 0) begin
                    res_ch.ready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (res_ch.valid !== 1'b1) @(posedge clk);
            ledger.check_result(res_ch.frame_index, res_ch.status, res_ch.last);
            @(negedge clk);
        end
    end

    initial begin
        logic [BYTES_W-1:0] pages [5];
        ledger       = new();
        cycles       = 0;
        n_pages      = 0;
        quiet        = 1'b0;
        pressure_req = 1'b0;
        rst_n                <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.action        <= ACT_ALLOC;
        req_ch.process_id    <= '0;
        req_ch.request_bytes <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.page_bytes    <= '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // full list, exact fit, short, double release, zero size
        write_page(16'd4096);
        drive_request(ACT_ALLOC, 8'd0, 16'd0);
        drive_request(ACT_RELEASE, 8'd5, 16'd0);
        drive_request(ACT_ALLOC, 8'd1, 16'd1);
        drive_request(ACT_ALLOC, 8'd2, 16'd4096);
        drive_request(ACT_ALLOC, 8'd3, 16'd4097);
        drive_request(ACT_ALLOC, 8'd255, 16'hFFFF);
        drive_request(ACT_RELEASE, 8'd2, 16'hFFFF);
        drive_request(ACT_ALLOC, 8'd4, 16'hFFFF);
        drive_request(ACT_ALLOC, 8'd5, 16'hFFFF);
        drive_request(ACT_ALLOC, 8'd6, 16'hFFFF);
        drive_request(ACT_ALLOC, 8'd6, 16'd53248);
        drive_request(ACT_ALLOC, 8'd7, 16'd1);
        drive_request(ACT_RELEASE, 8'd255, 16'd0);
        drive_request(ACT_RELEASE, 8'd255, 16'd0);
        drive_request(ACT_RELEASE, 8'd1, 16'd0);
        drive_request(ACT_RELEASE, 8'd3, 16'd0);
        drive_request(ACT_RELEASE, 8'd4, 16'd0);
        drive_request(ACT_RELEASE, 8'd5, 16'd0);
        drive_request(ACT_RELEASE, 8'd6, 16'd0);
        write_page(16'd1024);
        drive_request(ACT_ALLOC, 8'd200, 16'hFFFF);
        drive_request(ACT_RELEASE, 8'd200, 16'd0);
        write_page(16'hFFFF);
        drive_request(ACT_ALLOC, 8'd0, 16'hFFFF);
        drive_request(ACT_RELEASE, 8'd0, 16'd0);
        // zero page size behaves as one byte per page
        write_page(16'd0);
        drive_request(ACT_ALLOC, 8'd8, 16'd3);
        drive_request(ACT_RELEASE, 8'd8, 16'd0);

        pages = '{16'd1, 16'd1000, 16'hFFFF, 16'd4096, 16'($urandom_range(1, 65535))};
        for (int ph = 0; ph < 5; ph++) begin
            write_page(pages[ph]);
            quiet = (ph == 3);
            if (ph == 1) pressure_req = 1'b1;
            repeat (PHASE_ITEMS) random_item();
        end
        quiet = 1'b0;

        settle();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (ledger.waiting() != 0) begin
            $display("%0t: %0d expected result beats never arrived",
                     $time, ledger.waiting());
            ledger.errors++;
        end
        $display("run: %0d requests under %0d page size writes, incl. a %0d-cycle stall",
                 ledger.n_requests, n_pages, PRESSURE_LEN);
        $display("beats: %0d granted, %0d released, %0d short, %0d nothing to do",
                 ledger.n_granted, ledger.n_released, ledger.n_short, ledger.n_empty);
        if (ledger.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
